// ===== design/srtg_pkg.sv =====
package srtg_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int TICK_BITS_DEF   = 16;
   localparam int STEP_BITS_DEF   = 24;

   localparam int OP_W           = 2;
   localparam int INDEX_W        = 8;
   localparam int VALUE_W        = 16;
   localparam int ACCEL_W        = 8;
   localparam int CRUISE_STEPS_W = 24;
   localparam int CRUISE_TICKS_W = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 24;
   localparam int PHASE_W        = 2;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_STEPS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRUISE_STEPS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRUISE_TICKS = 2'd2;

   localparam logic [CRUISE_TICKS_W-1:0] CRUISE_TICKS_RST = 16'd1;

   typedef struct packed {
      logic               step_pulse;
      logic [PHASE_W-1:0] phase;
      logic               move_done;
      logic               busy_res;
   } rsp_payload_type;

endpackage

// ===== design/srtg_req_if.sv =====
interface srtg_req_if;
   logic                           valid;
   logic                           ready;
   logic [srtg_pkg::OP_W-1:0]      operation;
   logic [srtg_pkg::INDEX_W-1:0]   table_index;
   logic [srtg_pkg::VALUE_W-1:0]   table_value;

   modport source (output valid, output operation, output table_index,
                   output table_value, input ready);
   modport sink (input valid, input operation, input table_index,
                 input table_value, output ready);
endinterface

// ===== design/srtg_rsp_if.sv =====
interface srtg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           step_pulse;
   logic [srtg_pkg::PHASE_W-1:0]   phase;
   logic                           move_done;
   logic                           busy_res;

   modport source (output valid, output step_pulse, output phase,
                   output move_done, output busy_res, input ready);
   modport sink (input valid, input step_pulse, input phase,
                 input move_done, input busy_res, output ready);
endinterface

// ===== design/srtg_ramp_mem.sv =====
module srtg_ramp_mem #(
   parameter int DEPTH = srtg_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [srtg_pkg::VALUE_W-1:0]        wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [srtg_pkg::VALUE_W-1:0]        rd_data
);

   logic [srtg_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [srtg_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/srtg_rsp_stage.sv =====
module srtg_rsp_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  srtg_pkg::rsp_payload_type push_data,
   output logic                      can_push,
   srtg_rsp_if.source                rsp_bus
);

   logic                      valid_ff;
   logic                      valid_in;
   srtg_pkg::rsp_payload_type data_ff;

   assign can_push = !valid_ff || rsp_bus.ready;
   assign valid_in = push || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.step_pulse = data_ff.step_pulse;
   assign rsp_bus.phase      = data_ff.phase;
   assign rsp_bus.move_done  = data_ff.move_done;
   assign rsp_bus.busy_res   = data_ff.busy_res;

endmodule

// ===== design/stepper_trapezoid_ramp_generator.sv =====
// Channel   Direction  Handshake            Payload
// req_bus   in         valid/ready          operation, table_index, table_value
// rsp_bus   out        valid/ready          step_pulse, phase, move_done, busy_res
// csr_*     in         csr_wr_en            csr_index, csr_wdata
//
// One transaction per cycle while req_bus.ready is high; each request yields one registered response.
// The ramp table read is issued in the cycle that needs the next interval and
// its registered data is taken by the next tick transaction.
// Synchronous active-high reset clears phase and counters; table is not cleared.
// req_bus.ready drops only while the response register is full and stalled.
module stepper_trapezoid_ramp_generator #(
   parameter int TABLE_DEPTH = srtg_pkg::TABLE_DEPTH_DEF,
   parameter int TICK_BITS   = srtg_pkg::TICK_BITS_DEF,
   parameter int STEP_BITS   = srtg_pkg::STEP_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   srtg_req_if.sink                             req_bus,
   srtg_rsp_if.source                           rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [srtg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [srtg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int TW = (TICK_BITS > srtg_pkg::VALUE_W) ? TICK_BITS : srtg_pkg::VALUE_W;
   localparam int SW = (STEP_BITS > srtg_pkg::CRUISE_STEPS_W) ?
                       STEP_BITS : srtg_pkg::CRUISE_STEPS_W;
   localparam logic [TW-1:0] TickMax = TW'((64'd1 << TICK_BITS) - 64'd1);
   localparam logic [SW-1:0] StepMax = SW'((64'd1 << STEP_BITS) - 64'd1);
   localparam int PosCount = 1 << srtg_pkg::ACCEL_W;

   logic [srtg_pkg::ACCEL_W-1:0]        accel_steps_ff;
   logic [srtg_pkg::CRUISE_STEPS_W-1:0] cruise_steps_ff;
   logic [srtg_pkg::CRUISE_TICKS_W-1:0] cruise_ticks_ff;

   logic [srtg_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [TICK_BITS-1:0]         ticks_ff, ticks_in;
   logic                         pend_ff, pend_in;
   logic [STEP_BITS-1:0]         steps_ff, steps_in;
   logic [srtg_pkg::ACCEL_W-1:0] pos_ff, pos_in;

   logic                         fire;
   logic                         can_push;
   logic                         rd_en;
   logic [srtg_pkg::ACCEL_W-1:0] rd_pos;
   logic [AW-1:0]                pos_mod [PosCount];
   logic [srtg_pkg::VALUE_W-1:0] rd_data;
   logic                         wr_en;
   logic [TICK_BITS-1:0]         tick_cur;
   logic [TICK_BITS-1:0]         cruise_iv;
   logic [STEP_BITS-1:0]         cruise_len;
   logic [STEP_BITS-1:0]         accel_len;
   logic [STEP_BITS-1:0]         steps_dec;
   logic                         pulse;
   logic                         done;
   srtg_pkg::rsp_payload_type    rsp_data;

   function automatic logic [TICK_BITS-1:0] clamp_iv(
      input logic [srtg_pkg::VALUE_W-1:0] v
   );
      logic [TW-1:0] vx;
      vx = TW'(v);
      if (vx == '0) begin
         vx = TW'(1);
      end else if (vx > TickMax) begin
         vx = TickMax;
      end
      return TICK_BITS'(vx);
   endfunction

   for (genvar i = 0; i < PosCount; i++) begin : g_pos_mod
      assign pos_mod[i] = AW'(i % TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_steps_ff  <= '0;
         cruise_steps_ff <= '0;
         cruise_ticks_ff <= srtg_pkg::CRUISE_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            srtg_pkg::CSR_ACCEL_STEPS: begin
               accel_steps_ff <= csr_wdata[srtg_pkg::ACCEL_W-1:0];
            end
            srtg_pkg::CSR_CRUISE_STEPS: begin
               cruise_steps_ff <= csr_wdata[srtg_pkg::CRUISE_STEPS_W-1:0];
            end
            srtg_pkg::CSR_CRUISE_TICKS: begin
               cruise_ticks_ff <= csr_wdata[srtg_pkg::CRUISE_TICKS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign fire          = req_bus.valid && can_push;
   assign req_bus.ready = can_push;

   assign tick_cur   = pend_ff ? clamp_iv(rd_data) : ticks_ff;
   assign cruise_iv  = clamp_iv(cruise_ticks_ff);
   assign cruise_len = (SW'(cruise_steps_ff) > StepMax) ? STEP_BITS'(StepMax)
                                                        : STEP_BITS'(cruise_steps_ff);
   assign accel_len  = STEP_BITS'(accel_steps_ff);
   assign steps_dec  = (steps_ff != '0) ? steps_ff - STEP_BITS'(1) : '0;

   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      pend_in  = pend_ff;
      steps_in = steps_ff;
      pos_in   = pos_ff;
      rd_en    = 1'b0;
      rd_pos   = pos_ff;
      wr_en    = 1'b0;
      pulse    = 1'b0;
      done     = 1'b0;
      if (fire) begin
         case (req_bus.operation)
            srtg_pkg::OP_TICK: begin
               if (phase_ff != srtg_pkg::PH_IDLE) begin
                  if (tick_cur > TICK_BITS'(1)) begin
                     ticks_in = tick_cur - TICK_BITS'(1);
                     pend_in  = 1'b0;
                  end else begin
                     pulse    = 1'b1;
                     steps_in = steps_dec;
                     if (steps_dec == '0) begin
                        if (phase_ff == srtg_pkg::PH_ACCEL && cruise_steps_ff != '0) begin
                           phase_in = srtg_pkg::PH_CRUISE;
                           steps_in = cruise_len;
                           ticks_in = cruise_iv;
                           pend_in  = 1'b0;
                        end else if (phase_ff != srtg_pkg::PH_DECEL &&
                                     accel_steps_ff != '0) begin
                           phase_in = srtg_pkg::PH_DECEL;
                           steps_in = accel_len;
                           pos_in   = accel_steps_ff;
                           rd_en    = 1'b1;
                           rd_pos   = accel_steps_ff;
                           pend_in  = 1'b1;
                        end else begin
                           phase_in = srtg_pkg::PH_IDLE;
                           ticks_in = '0;
                           steps_in = '0;
                           pos_in   = '0;
                           pend_in  = 1'b0;
                           done     = 1'b1;
                        end
                     end else begin
                        case (phase_ff)
                           srtg_pkg::PH_ACCEL: begin
                              rd_en   = 1'b1;
                              rd_pos  = pos_ff;
                              pend_in = 1'b1;
                              pos_in  = pos_ff + srtg_pkg::ACCEL_W'(1);
                           end
                           srtg_pkg::PH_DECEL: begin
                              rd_en   = 1'b1;
                              rd_pos  = pos_ff - srtg_pkg::ACCEL_W'(1);
                              pend_in = 1'b1;
                              pos_in  = pos_ff - srtg_pkg::ACCEL_W'(1);
                           end
                           default: begin
                              ticks_in = cruise_iv;
                              pend_in  = 1'b0;
                           end
                        endcase
                     end
                  end
               end
            end
            srtg_pkg::OP_START: begin
               if (accel_steps_ff != '0) begin
                  phase_in = srtg_pkg::PH_ACCEL;
                  steps_in = accel_len;
                  rd_en    = 1'b1;
                  rd_pos   = '0;
                  pend_in  = 1'b1;
                  pos_in   = srtg_pkg::ACCEL_W'(1);
               end else if (cruise_steps_ff != '0) begin
                  phase_in = srtg_pkg::PH_CRUISE;
                  steps_in = cruise_len;
                  ticks_in = cruise_iv;
                  pend_in  = 1'b0;
               end else begin
                  phase_in = srtg_pkg::PH_IDLE;
                  ticks_in = '0;
                  steps_in = '0;
                  pos_in   = '0;
                  pend_in  = 1'b0;
                  done     = 1'b1;
               end
            end
            srtg_pkg::OP_WRITE: begin
               wr_en = (phase_ff == srtg_pkg::PH_IDLE) &&
                       (32'(req_bus.table_index) < 32'(TABLE_DEPTH));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= srtg_pkg::PH_IDLE;
         ticks_ff <= '0;
         pend_ff  <= 1'b0;
         steps_ff <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         pend_ff  <= pend_in;
         steps_ff <= steps_in;
         pos_ff   <= pos_in;
      end
   end

   srtg_ramp_mem #(
      .DEPTH (TABLE_DEPTH)
   ) u_ramp_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_bus.table_index)),
      .wr_data ((req_bus.table_value == '0) ? srtg_pkg::VALUE_W'(1)
                                            : req_bus.table_value),
      .rd_en   (rd_en),
      .rd_addr (pos_mod[rd_pos]),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_data.step_pulse = pulse;
      rsp_data.phase      = phase_in;
      rsp_data.move_done  = done;
      rsp_data.busy_res   = (phase_in != srtg_pkg::PH_IDLE);
   end

   srtg_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (rsp_data),
      .can_push  (can_push),
      .rsp_bus   (rsp_bus)
   );

endmodule
